>>> rtl/core/fmrm_pkg.sv
package fmrm_pkg;

  typedef enum logic [1:0] {
    OP_NOTE_ON = 2'd0,
    OP_PARAM   = 2'd1,
    OP_COEF    = 2'd2,
    OP_TICK    = 2'd3
  } op_code_t;

  localparam logic [1:0] PAR_MULT   = 2'd0;
  localparam logic [1:0] PAR_OFFSET = 2'd1;
  localparam logic [1:0] PAR_START  = 2'd2;
  localparam logic [1:0] PAR_GAIN   = 2'd3;
  localparam logic [1:0] COEF_FM    = 2'd0;
  localparam logic [1:0] COEF_RM    = 2'd1;

  localparam logic [31:0] PPH_RESET   = 32'd89478;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [25:0] FREQ_MAX  = 26'sh1FFFFFF;
  localparam logic signed [25:0] FREQ_MIN  = -26'sh2000000;
  localparam logic signed [21:0] RM_LIM    = 22'sd1048576;
  localparam logic signed [21:0] RM_UNITY  = 22'sd16384;
  localparam logic signed [15:0] Q15_MAX   = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN   = -16'sh8000;
  localparam logic signed [19:0] SMP_MAX   = 20'sh7FFFF;
  localparam logic signed [19:0] SMP_MIN   = -20'sh80000;

  // per-operator word: parameters and running state
  typedef struct packed {
    logic        [15:0] mult;
    logic signed [21:0] offset;
    logic        [15:0] start;
    logic signed [15:0] gain;
    logic        [31:0] phase;
    logic signed [15:0] last;
    logic signed [25:0] freq;
  } op_word_t;

  typedef struct packed {
    logic signed [15:0] fm;
    logic signed [15:0] rm;
  } coef_word_t;

  // quarter-wave entry k, table of 2^qshift steps, Taylor series to x^13
  function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qshift);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    longint      v;
    x    = (64'(k) * HALF_PI_Q30) >> qshift;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + longint'(term);
    if (acc < 0) acc = 0;
    v = (acc * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

endpackage

>>> rtl/core/fm_rm_operator_matrix_core.sv
// Six-operator (OPERATORS) FM / ring-modulation voice. Send note-on, parameter and matrix
// writes and sample ticks on the input stream; each tick returns one saturated Q4.15 sample.
// Operator parameters and running state sit in a small RAM, the coefficient matrix in a second
// RAM; the voice reads, updates and writes them back one access per cycle. A tick walks every
// operator through S_OP_RD, S_OP_FREQ and S_OP_SAT, then a per-source read-multiply-accumulate
// loop of S_SRC_RD, S_SRC_MUL, S_SRC_MAC and S_SRC_UPD for each matrix term, then S_INST
// to S_MIX. A note-on rewrites each operator's word in turn. A finished sample waits in the
// output register while the next transaction is already taken.
module fm_rm_operator_matrix_core #(
  parameter int OPERATORS       = 6,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // base_freq[23:0], src_index, dst_index, which, value
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sample[19:0], zero pad
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import fmrm_pkg::*;

  localparam int OW = OPERATORS > 1 ? $clog2(OPERATORS) : 1;
  localparam int CD = OPERATORS * OPERATORS;
  localparam int CA = $clog2(CD);

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_NOTE_RD = 22'h000002,
    S_NOTE_WR = 22'h000004,
    S_PAR_RD  = 22'h000008,
    S_PAR_WR  = 22'h000010,
    S_COEF_RD = 22'h000020,
    S_COEF_WR = 22'h000040,
    S_OP_RD   = 22'h000080,
    S_OP_FREQ = 22'h000100,
    S_OP_SAT  = 22'h000200,
    S_SRC_RD  = 22'h000400,
    S_SRC_MUL = 22'h000800,
    S_SRC_MAC = 22'h001000,
    S_SRC_UPD = 22'h002000,
    S_INST    = 22'h004000,
    S_STEP    = 22'h008000,
    S_PHASE   = 22'h010000,
    S_SINE    = 22'h020000,
    S_OUTMUL  = 22'h040000,
    S_OUT_WR  = 22'h080000,
    S_MIX     = 22'h100000,
    S_DONE    = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] pph_r;
  logic [23:0] base_r;
  logic [2:0]  si_r, di_r;
  logic [1:0]  which_r;
  logic [31:0] val_r;
  logic [OW-1:0] t_r, s_r;

  op_word_t   opw_r;
  logic [39:0]        fprod_r;
  logic signed [25:0] opf_t_r;
  logic signed [41:0] p1_r;
  logic signed [31:0] q_r;
  logic signed [15:0] fmc_r, rmc_r;
  logic signed [57:0] p2_r;
  logic signed [40:0] m_r;
  logic signed [63:0] acc_r;
  logic signed [21:0] depth_r;
  logic signed [25:0] inst_r;
  logic signed [58:0] stepm_r;
  logic [31:0]        phase_new_r;
  logic signed [37:0] oprod_r;
  logic signed [15:0] o_r;
  logic signed [35:0] mix_r;
  logic               out_tvalid_r;
  logic signed [19:0] sample_r;
  logic signed [15:0] sine;

  // RAM ports
  logic          op_we;
  logic [OW-1:0] op_waddr, op_raddr;
  op_word_t      op_wdata, op_rdata;
  logic          cf_we;
  logic [CA-1:0] cf_waddr, cf_raddr;
  coef_word_t    cf_wdata, cf_rdata;

  fmrm_ram #(.WIDTH($bits(op_word_t)), .DEPTH(OPERATORS)) u_opmem (
    .clk(clk), .rst_n(rst_n), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
    .raddr(op_raddr), .rdata(op_rdata)
  );

  fmrm_ram #(.WIDTH($bits(coef_word_t)), .DEPTH(CD)) u_coefmem (
    .clk(clk), .rst_n(rst_n), .we(cf_we), .waddr(cf_waddr), .wdata(cf_wdata),
    .raddr(cf_raddr), .rdata(cf_rdata)
  );

  fmrm_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
    .clk(clk), .phase(phase_new_r), .sine_r(sine)
  );

  logic in_acc;
  logic t_last, s_last;
  logic signed [25:0] freq_s;
  logic signed [31:0] f_sum;
  logic signed [25:0] f_sat;
  logic signed [16:0] rabs;
  logic signed [18:0] fac;
  logic signed [26:0] dsh;
  logic signed [21:0] d_sat;
  logic signed [37:0] isum;
  logic signed [25:0] i_sat;
  logic signed [23:0] osh;
  logic signed [15:0] o_sat;
  logic signed [21:0] msh;
  logic signed [19:0] smp_sat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign t_last    = (t_r == OW'(OPERATORS - 1));
  assign s_last    = (s_r == OW'(OPERATORS - 1));

  // operator t sees its own fresh frequency
  assign freq_s = (s_r == t_r) ? opf_t_r : op_rdata.freq;
  assign f_sum  = $signed({2'b00, fprod_r[39:10]}) + 32'(opw_r.offset);
  assign f_sat  = (f_sum > 32'(FREQ_MAX)) ? FREQ_MAX :
                  (f_sum < 32'(FREQ_MIN)) ? FREQ_MIN : f_sum[25:0];
  assign rabs   = rmc_r[15] ? -17'(rmc_r) : 17'(rmc_r);
  assign fac    = 19'sd16384 + 19'(q_r >>> 15) - 19'(rabs);
  assign dsh    = 27'(m_r >>> 14);
  assign d_sat  = (dsh > 27'(RM_LIM)) ? RM_LIM :
                  (dsh < -27'(RM_LIM)) ? -RM_LIM : dsh[21:0];
  assign isum   = 38'(opf_t_r) + 38'(acc_r >>> 27);
  assign i_sat  = (isum > 38'(FREQ_MAX)) ? FREQ_MAX :
                  (isum < 38'(FREQ_MIN)) ? FREQ_MIN : isum[25:0];
  assign osh    = 24'(oprod_r >>> 14);
  assign o_sat  = (osh > 24'(Q15_MAX)) ? Q15_MAX :
                  (osh < 24'(Q15_MIN)) ? Q15_MIN : osh[15:0];
  assign msh    = 22'(mix_r >>> 14);
  assign smp_sat = (msh > 22'(SMP_MAX)) ? SMP_MAX :
                   (msh < 22'(SMP_MIN)) ? SMP_MIN : msh[19:0];

  always_comb begin
    op_we    = 1'b0;
    op_waddr = t_r;
    op_wdata = op_rdata;
    op_raddr = t_r;
    cf_we    = 1'b0;
    cf_waddr = CA'(int'(si_r) * OPERATORS + int'(di_r));
    cf_wdata = cf_rdata;
    cf_raddr = CA'(int'(s_r) * OPERATORS + int'(t_r));
    unique case (state_r)
      S_PAR_RD:  op_raddr = OW'(si_r);
      S_SRC_RD:  op_raddr = s_r;
      S_COEF_RD: cf_raddr = cf_waddr;
      S_NOTE_WR: begin
        op_we          = 1'b1;
        op_wdata.phase = {op_rdata.start, 16'h0000};
        op_wdata.last  = '0;
        op_wdata.freq  = '0;
      end
      S_PAR_WR: begin
        op_we    = 1'b1;
        op_waddr = OW'(si_r);
        unique case (which_r)
          PAR_MULT:   op_wdata.mult   = val_r[15:0];
          PAR_OFFSET: op_wdata.offset = val_r[21:0];
          PAR_START:  op_wdata.start  = val_r[15:0];
          PAR_GAIN:   op_wdata.gain   = val_r[15:0];
          default:    op_wdata.mult   = val_r[15:0];
        endcase
      end
      S_COEF_WR: begin
        cf_we = 1'b1;
        if (which_r == COEF_FM) cf_wdata.fm = val_r[15:0];
        else                    cf_wdata.rm = val_r[15:0];
      end
      S_OUT_WR: begin
        op_we          = 1'b1;
        op_wdata       = opw_r;
        op_wdata.phase = phase_new_r;
        op_wdata.last  = o_sat;
        op_wdata.freq  = opf_t_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_code_t'(in_tuser))
            OP_NOTE_ON: state_nxt = S_NOTE_RD;
            OP_PARAM:   if (in_tdata[26:24] < OPERATORS) state_nxt = S_PAR_RD;
            OP_COEF:    if (in_tdata[26:24] < OPERATORS && in_tdata[29:27] < OPERATORS &&
                            (in_tdata[31:30] == COEF_FM || in_tdata[31:30] == COEF_RM))
                          state_nxt = S_COEF_RD;
            OP_TICK:    state_nxt = S_OP_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_NOTE_RD: state_nxt = S_NOTE_WR;
      S_NOTE_WR: state_nxt = t_last ? S_IDLE : S_NOTE_RD;
      S_PAR_RD:  state_nxt = S_PAR_WR;
      S_PAR_WR:  state_nxt = S_IDLE;
      S_COEF_RD: state_nxt = S_COEF_WR;
      S_COEF_WR: state_nxt = S_IDLE;
      S_OP_RD:   state_nxt = S_OP_FREQ;
      S_OP_FREQ: state_nxt = S_OP_SAT;
      S_OP_SAT:  state_nxt = S_SRC_RD;
      S_SRC_RD:  state_nxt = S_SRC_MUL;
      S_SRC_MUL: state_nxt = S_SRC_MAC;
      S_SRC_MAC: state_nxt = S_SRC_UPD;
      S_SRC_UPD: state_nxt = s_last ? S_INST : S_SRC_RD;
      S_INST:    state_nxt = S_STEP;
      S_STEP:    state_nxt = S_PHASE;
      S_PHASE:   state_nxt = S_SINE;
      S_SINE:    state_nxt = S_OUTMUL;
      S_OUTMUL:  state_nxt = S_OUT_WR;
      S_OUT_WR:  state_nxt = S_MIX;
      S_MIX:     state_nxt = t_last ? S_DONE : S_OP_RD;
      S_DONE:    if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pph_r        <= PPH_RESET;
      t_r          <= '0;
      s_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) pph_r <= cfg_wdata;
      if (in_acc) t_r <= '0;
      if ((state_r == S_NOTE_WR || state_r == S_MIX) && !t_last) t_r <= t_r + 1'b1;
      if (state_r == S_OP_SAT) s_r <= '0;
      if (state_r == S_SRC_UPD && !s_last) s_r <= s_r + 1'b1;
      // hold the sample until taken
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r  <= in_tdata[23:0];
      si_r    <= in_tdata[26:24];
      di_r    <= in_tdata[29:27];
      which_r <= in_tdata[31:30];
      val_r   <= in_tdata[63:32];
      mix_r   <= '0;
    end
    if (state_r == S_OP_FREQ) begin
      opw_r   <= op_rdata;
      fprod_r <= 40'(base_r) * 40'(op_rdata.mult);
    end
    if (state_r == S_OP_SAT) begin
      opf_t_r <= f_sat;
      acc_r   <= '0;
      depth_r <= RM_UNITY;
    end
    if (state_r == S_SRC_MUL) begin
      p1_r  <= 42'(freq_s) * 42'(op_rdata.last);
      q_r   <= 32'(op_rdata.last) * 32'(cf_rdata.rm);
      fmc_r <= cf_rdata.fm;
      rmc_r <= cf_rdata.rm;
    end
    if (state_r == S_SRC_MAC) begin
      p2_r <= 58'(p1_r) * 58'(fmc_r);
      m_r  <= 41'(depth_r) * 41'(fac);
    end
    if (state_r == S_SRC_UPD) begin
      acc_r   <= acc_r + 64'(p2_r);
      depth_r <= d_sat;
    end
    if (state_r == S_INST)   inst_r      <= i_sat;
    if (state_r == S_STEP)   stepm_r     <= 59'(inst_r) * 59'($signed({1'b0, pph_r}));
    if (state_r == S_PHASE)  phase_new_r <= opw_r.phase + stepm_r[35:4];
    if (state_r == S_OUTMUL) oprod_r     <= 38'(sine) * 38'(depth_r);
    if (state_r == S_OUT_WR) o_r         <= o_sat;
    if (state_r == S_MIX)    mix_r       <= mix_r + 36'(o_r) * 36'(opw_r.gain);
    if (state_r == S_DONE && (!out_tvalid_r || out_tready)) sample_r <= smp_sat;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'h0, sample_r};

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("sample raised outside final state");

  a_opmem_we: assert property (@(posedge clk) disable iff (!rst_n)
    op_we |-> (state_r == S_NOTE_WR || state_r == S_PAR_WR || state_r == S_OUT_WR))
    else $error("operator RAM written outside a write state");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUTMUL) |-> (depth_r <= RM_LIM && depth_r >= -RM_LIM))
    else $error("ring depth out of range");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (t_r < OPERATORS) && (s_r < OPERATORS))
    else $error("operator counter out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRC_RD) |-> !op_we && !cf_we)
    else $error("RAM write during source read");

endmodule

>>> rtl/core/fmrm_ram.sv
module fmrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

>>> rtl/core/fmrm_sine.sv
module fmrm_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [15:0] sine_r
);
  import fmrm_pkg::*;

  localparam int B   = SINE_TABLE_BITS;
  localparam int QTR = 1 << (B - 2);

  logic [14:0]  tbl [QTR+1];
  logic [B-1:0] idx;
  logic [1:0]   quad;
  logic [B-3:0] pos;
  logic [B-2:0] addr;
  logic [15:0]  mag;

  for (genvar k = 0; k <= QTR; k++) begin : g_tbl
    localparam logic [14:0] V = sine_entry(k, B - 2);
    assign tbl[k] = V;
  end

  assign idx  = phase[31 -: B];
  assign quad = idx[B-1:B-2];
  assign pos  = idx[B-3:0];
  assign addr = quad[0] ? ((B-1)'(QTR) - (B-1)'(pos)) : (B-1)'(pos);
  assign mag  = {1'b0, tbl[addr]};

  always_ff @(posedge clk) begin
    sine_r <= quad[1] ? -$signed(mag) : $signed(mag);
  end

endmodule
